[sv/ipbf_pkg.sv]
`timescale 1ns / 1ps
package ipbf_pkg;

    localparam int BLOCK_ENTRIES = 4096;
    localparam int BLK_AW        = $clog2(BLOCK_ENTRIES);
    localparam int PORT_AW       = 16;

    localparam logic [2:0] FUNC_FRAME    = 3'd0;
    localparam logic [2:0] FUNC_BLK_ADD  = 3'd1;
    localparam logic [2:0] FUNC_BLK_DEL  = 3'd2;
    localparam logic [2:0] FUNC_PORT_SET = 3'd3;
    localparam logic [2:0] FUNC_PORT_CLR = 3'd4;

    localparam logic [1:0] PORT_NONE  = 2'd0;
    localparam logic [1:0] PORT_TCP   = 2'd1;
    localparam logic [1:0] PORT_UDP   = 2'd2;
    localparam logic [1:0] PORT_OTHER = 2'd3;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_BLOCKED = 2'd1;
    localparam logic [1:0] CAUSE_PORT    = 2'd2;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    // One unit of work for the back end: a finished frame or a table update.
    typedef struct packed {
        logic [2:0]  func;
        logic        blk_chk;   // frame needs the blocklist lookup
        logic        l4_chk;    // frame needs the port lookup if not blocked
        logic [1:0]  want;      // port code the frame must find
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  proto;
    } job_t;

endpackage

[sv/ipbf_front.sv]
`timescale 1ns / 1ps
module ipbf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               init_done,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         func,
    input  logic [7:0]         frame_byte,
    input  logic               frame_last,
    input  logic [31:0]        ip_address,
    input  logic [15:0]        port_number,
    input  logic [7:0]         protocol_number,
    output logic               q_push,
    output ipbf_pkg::job_t     q_job,
    input  logic               q_full
);
    import ipbf_pkg::*;

    logic [5:0]  pos_reg, pos_next;
    logic        ipv4_reg, ipv4_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [15:0] dport_reg, dport_next;

    logic        accept;
    logic        is_frame;
    logic        is_update;
    logic        c_ipv4;
    logic [7:0]  c_proto;
    logic [31:0] c_src;
    logic [15:0] c_dport;
    logic [6:0]  len;
    logic        tcp;
    logic        udp;
    logic        blk_chk;

    assign in_stall  = !init_done || q_full;
    assign accept    = in_valid && !in_stall;
    assign is_frame  = (func == FUNC_FRAME);
    assign is_update = (func == FUNC_BLK_ADD) || (func == FUNC_BLK_DEL) ||
                       (func == FUNC_PORT_SET) || (func == FUNC_PORT_CLR);

    // header capture including the present byte
    always_comb
    begin
        c_ipv4  = ipv4_reg;
        c_proto = proto_reg;
        c_src   = src_reg;
        c_dport = dport_reg;
        if (pos_reg == 6'd12)
        begin
            c_ipv4 = (frame_byte == 8'h08);
        end
        else if (pos_reg == 6'd13)
        begin
            c_ipv4 = ipv4_reg && (frame_byte == 8'h00);
        end
        else if (pos_reg == 6'd23)
        begin
            c_proto = frame_byte;
        end
        else if (pos_reg >= 6'd26 && pos_reg <= 6'd29)
        begin
            c_src = {src_reg[23:0], frame_byte};
        end
        else if (pos_reg == 6'd36 || pos_reg == 6'd37)
        begin
            c_dport = {dport_reg[7:0], frame_byte};
        end
    end

    assign len     = {1'b0, pos_reg} + 7'd1;
    assign tcp     = (c_proto == PROTO_TCP);
    assign udp     = (c_proto == PROTO_UDP);
    assign blk_chk = (len >= 7'd34) && c_ipv4;

    always_comb
    begin
        pos_next   = pos_reg;
        ipv4_next  = ipv4_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dport_next = dport_reg;
        if (accept && is_frame)
        begin
            if (frame_last)
            begin
                pos_next   = '0;
                ipv4_next  = 1'b0;
                proto_next = '0;
                src_next   = '0;
                dport_next = '0;
            end
            else
            begin
                if (pos_reg != 6'd63)
                begin
                    pos_next = pos_reg + 6'd1;
                end
                ipv4_next  = c_ipv4;
                proto_next = c_proto;
                src_next   = c_src;
                dport_next = c_dport;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            ipv4_reg  <= 1'b0;
            proto_reg <= '0;
            src_reg   <= '0;
            dport_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            ipv4_reg  <= ipv4_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dport_reg <= dport_next;
        end
    end

    assign q_push = accept && ((is_frame && frame_last) || is_update);

    always_comb
    begin
        q_job.func = func;
        if (is_frame)
        begin
            q_job.blk_chk = blk_chk;
            q_job.l4_chk  = blk_chk && ((tcp && len >= 7'd54) || (udp && len >= 7'd42));
            q_job.want    = tcp ? PORT_TCP : PORT_UDP;
            q_job.addr    = c_src;
            q_job.port    = c_dport;
            q_job.proto   = c_proto;
        end
        else
        begin
            q_job.blk_chk = 1'b0;
            q_job.l4_chk  = 1'b0;
            q_job.want    = PORT_NONE;
            q_job.addr    = ip_address;
            q_job.port    = port_number;
            q_job.proto   = protocol_number;
        end
    end

endmodule

[sv/ipbf_queue.sv]
`timescale 1ns / 1ps
module ipbf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ipbf_pkg::job_t job_in,
    output logic           full,
    input  logic           pop,
    output ipbf_pkg::job_t job_out,
    output logic           empty
);
    import ipbf_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign job_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> full)
        else $error("full queue lost an entry");
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty && !push |=> empty)
        else $error("empty queue gained an entry");

endmodule

[sv/ipbf_back.sv]
`timescale 1ns / 1ps
module ipbf_back (
    input  logic           clk,
    input  logic           rst_n,
    output logic           init_done,
    input  logic           q_empty,
    input  ipbf_pkg::job_t q_job,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           result_kind,
    output logic           verdict,
    output logic [1:0]     drop_cause,
    output logic [1:0]     update_status
);
    import ipbf_pkg::*;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_PCMP = 3'd3;

    logic [32:0] blk_mem [BLOCK_ENTRIES];
    logic [1:0]  port_mem [2**PORT_AW];

    logic [2:0]        state_reg, state_next;
    logic [PORT_AW-1:0] clr_reg, clr_next;
    job_t              job_reg, job_next;
    logic [BLK_AW:0]   issue_reg, issue_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [BLK_AW-1:0] chk_idx_reg, chk_idx_next;
    logic              free_seen_reg, free_seen_next;
    logic [BLK_AW-1:0] free_idx_reg, free_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, kind_next;
    logic              verdict_reg, verdict_next;
    logic [1:0]        cause_reg, cause_next;
    logic [1:0]        status_reg, status_next;

    logic [32:0]        blk_rd;
    logic [1:0]         port_rd;
    logic               blk_we;
    logic [BLK_AW-1:0]  blk_waddr;
    logic [32:0]        blk_wdata;
    logic [BLK_AW-1:0]  blk_raddr;
    logic               port_we;
    logic [PORT_AW-1:0] port_waddr;
    logic [1:0]         port_wdata;
    logic [PORT_AW-1:0] port_raddr;

    logic              hit;
    logic              cur_free;
    logic              free_any;
    logic [BLK_AW-1:0] free_at;
    logic              scan_last;

    assign init_done = (state_reg != ST_CLR);
    assign out_valid = out_valid_reg;
    assign result_kind   = kind_reg;
    assign verdict       = verdict_reg;
    assign drop_cause    = cause_reg;
    assign update_status = status_reg;

    assign hit       = chk_valid_reg && blk_rd[32] && (blk_rd[31:0] == job_reg.addr);
    assign cur_free  = chk_valid_reg && !blk_rd[32];
    assign free_any  = free_seen_reg || cur_free;
    assign free_at   = free_seen_reg ? free_idx_reg : chk_idx_reg;
    assign scan_last = chk_valid_reg && (chk_idx_reg == BLK_AW'(BLOCK_ENTRIES - 1));

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        job_next       = job_reg;
        issue_next     = issue_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        free_seen_next = free_seen_reg;
        free_idx_next  = free_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        verdict_next   = verdict_reg;
        cause_next     = cause_reg;
        status_next    = status_reg;
        q_pop          = 1'b0;
        blk_we         = 1'b0;
        blk_waddr      = chk_idx_reg;
        blk_wdata      = '0;
        blk_raddr      = issue_reg[BLK_AW-1:0];
        port_we        = 1'b0;
        port_waddr     = job_reg.port;
        port_wdata     = PORT_NONE;
        port_raddr     = job_reg.port;

        unique case (state_reg)
            ST_CLR:
            begin
                port_we    = 1'b1;
                port_waddr = clr_reg;
                blk_we     = ({1'b0, clr_reg} < (PORT_AW+1)'(BLOCK_ENTRIES));
                blk_waddr  = clr_reg[BLK_AW-1:0];
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                port_raddr = q_job.port;
                if (!out_valid_reg && !q_empty)
                begin
                    q_pop          = 1'b1;
                    job_next       = q_job;
                    issue_next     = '0;
                    free_seen_next = 1'b0;
                    kind_next      = KIND_ACK;
                    verdict_next   = 1'b0;
                    cause_next     = CAUSE_NONE;
                    status_next    = STAT_DONE;
                    unique case (q_job.func)
                        FUNC_FRAME:
                        begin
                            kind_next = KIND_VERDICT;
                            if (q_job.blk_chk)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        FUNC_BLK_ADD, FUNC_BLK_DEL:
                        begin
                            state_next = ST_SCAN;
                        end
                        FUNC_PORT_SET:
                        begin
                            port_we    = 1'b1;
                            port_waddr = q_job.port;
                            port_wdata = (q_job.proto == PROTO_TCP) ? PORT_TCP :
                                         (q_job.proto == PROTO_UDP) ? PORT_UDP : PORT_OTHER;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_PCMP;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issue_reg < (BLK_AW+1)'(BLOCK_ENTRIES))
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_reg[BLK_AW-1:0];
                    issue_next     = issue_reg + 1'b1;
                end
                if (cur_free && !free_seen_reg)
                begin
                    free_seen_next = 1'b1;
                    free_idx_next  = chk_idx_reg;
                end
                if (hit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (job_reg.func == FUNC_FRAME)
                    begin
                        verdict_next = 1'b1;
                        cause_next   = CAUSE_BLOCKED;
                    end
                    else if (job_reg.func == FUNC_BLK_DEL)
                    begin
                        blk_we    = 1'b1;
                        blk_waddr = chk_idx_reg;
                    end
                end
                else if (scan_last)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (job_reg.func == FUNC_FRAME)
                    begin
                        if (job_reg.l4_chk)
                        begin
                            state_next     = ST_PCMP;
                            out_valid_next = 1'b0;
                        end
                    end
                    else if (job_reg.func == FUNC_BLK_ADD)
                    begin
                        if (free_any)
                        begin
                            blk_we    = 1'b1;
                            blk_waddr = free_at;
                            blk_wdata = {1'b1, job_reg.addr};
                        end
                        else
                        begin
                            status_next = STAT_FULL;
                        end
                    end
                    else
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                end
            end
            ST_PCMP:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                if (job_reg.func == FUNC_FRAME)
                begin
                    if (port_rd != job_reg.want)
                    begin
                        verdict_next = 1'b1;
                        cause_next   = CAUSE_PORT;
                    end
                end
                else if (port_rd == PORT_NONE)
                begin
                    status_next = STAT_NOT_FOUND;
                end
                else
                begin
                    port_we = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        blk_rd <= blk_mem[blk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (port_we)
        begin
            port_mem[port_waddr] <= port_wdata;
        end
        port_rd <= port_mem[port_raddr];
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        issue_reg    <= issue_next;
        chk_idx_reg  <= chk_idx_next;
        free_idx_reg <= free_idx_next;
        kind_reg     <= kind_next;
        verdict_reg  <= verdict_next;
        cause_reg    <= cause_next;
        status_reg   <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_reg       <= '0;
            chk_valid_reg <= 1'b0;
            free_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            chk_valid_reg <= chk_valid_next;
            free_seen_reg <= free_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLR |-> !out_valid_reg)
        else $error("result during clearing pass");
    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !out_valid_reg && state_reg == ST_IDLE)
        else $error("job taken while busy");
    a_verdict_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_VERDICT |-> status_reg == STAT_DONE)
        else $error("verdict carries update status");
    a_pass_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !verdict_reg |-> cause_reg == CAUSE_NONE)
        else $error("pass with drop cause");

endmodule

[sv/ipv4_port_blocklist_filter_core.sv]
`timescale 1ns / 1ps
// IPv4 source blocklist and destination port filter. Frame bytes (func 0)
// enter one per cycle and are parsed on the fly at fixed header offsets
// (type 12..13, protocol 23, source 26..29, dest port 36..37); each frame's
// last byte and each table update become one transaction in a two-entry queue
// to the back end, which does the table work and returns one result per
// transaction. Timing: the front end takes a byte a cycle while the queue has
// room. In the back end a frame that needs the blocklist check and every
// blocklist add or remove scans the blocklist memory one entry per cycle (a
// hit ends the scan early); a frame that needs the port check then does the
// port lookup; port set writes the port table directly, port clear reads the
// entry first. A new transaction starts only once the previous result has been
// taken. After reset a clearing pass zeroes the port table and blocklist;
// in_stall stays high during it.
module ipv4_port_blocklist_filter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [7:0]  frame_byte,
    input  logic        frame_last,
    input  logic [31:0] ip_address,
    input  logic [15:0] port_number,
    input  logic [7:0]  protocol_number,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic        verdict,
    output logic [1:0]  drop_cause,
    output logic [1:0]  update_status
);
    import ipbf_pkg::*;

    logic init_done;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    job_t push_job;
    job_t head_job;

    // parser: header capture and job build
    ipbf_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .init_done       (init_done),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .frame_byte      (frame_byte),
        .frame_last      (frame_last),
        .ip_address      (ip_address),
        .port_number     (port_number),
        .protocol_number (protocol_number),
        .q_push          (q_push),
        .q_job           (push_job),
        .q_full          (q_full)
    );

    ipbf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .job_in  (push_job),
        .full    (q_full),
        .pop     (q_pop),
        .job_out (head_job),
        .empty   (q_empty)
    );

    // table engine: blocklist scan, port table, result register
    ipbf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .init_done     (init_done),
        .q_empty       (q_empty),
        .q_job         (head_job),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .verdict       (verdict),
        .drop_cause    (drop_cause),
        .update_status (update_status)
    );

endmodule
